FILE: hdl/fxa_pkg.sv
// ----------------------------------------------------------------------------
// fxa_pkg
// Shared constants and types for the fixed-point ALU pipeline.
// ----------------------------------------------------------------------------
package fxa_pkg;

  localparam int KIND_BITS = 4;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_ADD      = 4'd0,
    KIND_SUB      = 4'd1,
    KIND_MUL      = 4'd2,
    KIND_DIV      = 4'd3,
    KIND_MIN      = 4'd4,
    KIND_MAX      = 4'd5,
    KIND_INC      = 4'd6,
    KIND_DEC      = 4'd7,
    KIND_TO_INT   = 4'd8,
    KIND_FROM_INT = 4'd9,
    KIND_COMPARE  = 4'd10
  } kind_t;

  typedef enum logic [1:0] {
    ORDER_LESS    = 2'd0,
    ORDER_EQUAL   = 2'd1,
    ORDER_GREATER = 2'd2
  } order_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_DIV_ZERO = 2'd2
  } status_t;

endpackage

FILE: hdl/fixed_point_alu_q24_8_core.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8_core
// Signed fixed-point ALU with saturation, rounding multiply and divide.
// ----------------------------------------------------------------------------
// Fully pipelined: one item is accepted every cycle when the output side takes
// results. Items pass the stage 1 registers, the divider (one quotient bit per
// stage) and the output register; all kinds share that pipeline so results
// leave in order. A stall on the output freezes the whole pipeline.
module fixed_point_alu_q24_8_core #(
  parameter int FRAC_BITS = 8,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [3:0]                  kind,
  input  logic signed [WORD_BITS-1:0] operand_a,
  input  logic signed [WORD_BITS-1:0] operand_b,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [WORD_BITS-1:0] value,
  output logic [1:0]                  order,
  output logic [1:0]                  status
);

  localparam int W  = WORD_BITS;
  localparam int NB = W + FRAC_BITS;
  localparam int PB = 2 * W;
  localparam int LAT = NB;

  typedef struct packed {
    logic [3:0]     kind;
    logic           neg;
    logic           bzero;
    logic [W-1:0]   den;
    logic [W+1:0]   simple;
    logic           sat_simple;
    logic [PB-1:0]  prod;
    logic [1:0]     order;
  } ctx_t;

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: decode, magnitudes, simple ops
  ctx_t s1;
  logic s1_v;
  logic [W-1:0] ma, mb;
  logic signed [W+1:0] sa, sb, simple;
  logic sat_s;

  always_comb begin
    ma = operand_a[W-1] ? W'(-operand_a) : operand_a;
    mb = operand_b[W-1] ? W'(-operand_b) : operand_b;
    sa = (W+2)'(operand_a);
    sb = (W+2)'(operand_b);
    simple = '0;
    sat_s = 1'b1;
    unique case (kind)
      fxa_pkg::KIND_ADD: simple = sa + sb;
      fxa_pkg::KIND_SUB: simple = sa - sb;
      fxa_pkg::KIND_INC: simple = sa + (W+2)'(1);
      fxa_pkg::KIND_DEC: simple = sa - (W+2)'(1);
      fxa_pkg::KIND_MIN: begin
        simple = (operand_a < operand_b) ? sa : sb;
        sat_s = 1'b0;
      end
      fxa_pkg::KIND_MAX: begin
        simple = (operand_a > operand_b) ? sa : sb;
        sat_s = 1'b0;
      end
      fxa_pkg::KIND_TO_INT: begin
        simple = (W+2)'(ma >> FRAC_BITS);
        if (operand_a[W-1]) simple = -simple;
        sat_s = 1'b0;
      end
      fxa_pkg::KIND_FROM_INT: begin
        // out of range values are pushed just past the bounds
        if (&operand_a[W-1:W-1-FRAC_BITS] || ~|operand_a[W-1:W-1-FRAC_BITS]) begin
          simple = sa <<< FRAC_BITS;
        end else if (operand_a[W-1]) begin
          simple = {2'b11, 1'b0, {(W-1){1'b1}}};
        end else begin
          simple = {2'b00, 1'b1, {(W-1){1'b0}}};
        end
      end
      default: sat_s = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
    if (en) begin
      s1.kind       <= kind;
      s1.neg        <= operand_a[W-1] ^ operand_b[W-1];
      s1.bzero      <= (operand_b == '0);
      s1.den        <= mb;
      s1.simple     <= simple;
      s1.sat_simple <= sat_s;
      s1.prod       <= PB'(ma) * PB'(mb);
      s1.order      <= (operand_a < operand_b) ? fxa_pkg::ORDER_LESS :
                       (operand_a == operand_b) ? fxa_pkg::ORDER_EQUAL :
                       fxa_pkg::ORDER_GREATER;
    end
  end

  logic [NB-1:0] numer;
  assign numer = {ma, FRAC_BITS'(0)};

  logic [NB-1:0] numer_r;
  always_ff @(posedge clk) begin
    if (en) numer_r <= numer;
  end

  logic          dv;
  logic [NB-1:0] quo;
  logic [W:0]    rem;

  fxa_div #(.NUM_BITS(NB), .DEN_BITS(W)) u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(s1_v),
    .num(numer_r), .den(s1.den),
    .out_valid(dv), .quo(quo), .rem(rem)
  );

  // context delay alongside the divider
  ctx_t cd [LAT+1];
  assign cd[0] = s1;
  for (genvar i = 0; i < LAT; i++) begin : g_ctx
    ctx_t c_r;
    always_ff @(posedge clk) begin
      if (en) c_r <= cd[i];
    end
    assign cd[i+1] = c_r;
  end

  ctx_t c;
  assign c = cd[LAT];

  // final stage: rounding, sign, saturation
  logic [PB:0]    mag;
  logic [PB+1:0]  sv;
  logic [W-1:0]   v_next;
  logic [1:0]     st_next;
  logic [PB+1:0]  hi_b, lo_b;

  always_comb begin
    hi_b = (PB+2)'({1'b0, {(W-1){1'b1}}});
    lo_b = -hi_b - (PB+2)'(1);
    mag = '0;
    sv = '0;
    v_next = '0;
    st_next = fxa_pkg::STATUS_OK;
    unique case (c.kind)
      fxa_pkg::KIND_MUL: begin
        mag = (PB+1)'((c.prod + PB'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
        sv = c.neg ? -(PB+2)'(mag) : (PB+2)'(mag);
      end
      fxa_pkg::KIND_DIV: begin
        mag = (PB+1)'(quo) + (PB+1)'({rem, 1'b0} >= {2'b00, c.den});
        sv = c.neg ? -(PB+2)'(mag) : (PB+2)'(mag);
      end
      default: sv = (PB+2)'($signed(c.simple));
    endcase
    if (c.kind == fxa_pkg::KIND_DIV && c.bzero) begin
      v_next = '0;
      st_next = fxa_pkg::STATUS_DIV_ZERO;
    end else if ((c.kind == fxa_pkg::KIND_MUL || c.kind == fxa_pkg::KIND_DIV ||
                  c.kind == fxa_pkg::KIND_FROM_INT || c.sat_simple) &&
                 $signed(sv) > $signed(hi_b)) begin
      v_next = hi_b[W-1:0];
      st_next = fxa_pkg::STATUS_OVERFLOW;
    end else if ((c.kind == fxa_pkg::KIND_MUL || c.kind == fxa_pkg::KIND_DIV ||
                  c.kind == fxa_pkg::KIND_FROM_INT || c.sat_simple) &&
                 $signed(sv) < $signed(lo_b)) begin
      v_next = lo_b[W-1:0];
      st_next = fxa_pkg::STATUS_OVERFLOW;
    end else begin
      v_next = sv[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv;
    end
    if (en) begin
      value  <= v_next;
      order  <= c.order;
      status <= st_next;
    end
  end

endmodule

FILE: hdl/fxa_div.sv
// ----------------------------------------------------------------------------
// fxa_div
// Pipelined restoring divider, one quotient bit per stage, with stall.
// ----------------------------------------------------------------------------
module fxa_div #(
  parameter int NUM_BITS = 40,
  parameter int DEN_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                out_valid,
  output logic [NUM_BITS-1:0] quo,
  output logic [DEN_BITS:0]   rem
);

  logic [NUM_BITS:0]   vld;
  logic [NUM_BITS-1:0] qs [NUM_BITS+1];
  logic [DEN_BITS:0]   rs [NUM_BITS+1];
  logic [DEN_BITS-1:0] ds [NUM_BITS+1];

  assign vld[0] = in_valid;
  assign qs[0]  = num;
  assign rs[0]  = '0;
  assign ds[0]  = den;

  for (genvar i = 0; i < NUM_BITS; i++) begin : g_stage
    logic [DEN_BITS+1:0] shifted;
    logic [DEN_BITS+1:0] diff;
    logic                v_r;
    logic [NUM_BITS-1:0] q_r;
    logic [DEN_BITS:0]   r_r;
    logic [DEN_BITS-1:0] d_r;

    always_comb begin
      shifted = {rs[i], qs[i][NUM_BITS-1]};
      diff    = shifted - {2'b00, ds[i]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= vld[i];
      end
      if (en) begin
        d_r <= ds[i];
        if (!diff[DEN_BITS+1]) begin
          r_r <= diff[DEN_BITS:0];
          q_r <= {qs[i][NUM_BITS-2:0], 1'b1};
        end else begin
          r_r <= shifted[DEN_BITS:0];
          q_r <= {qs[i][NUM_BITS-2:0], 1'b0};
        end
      end
    end

    assign vld[i+1] = v_r;
    assign qs[i+1]  = q_r;
    assign rs[i+1]  = r_r;
    assign ds[i+1]  = d_r;
  end

  assign out_valid = vld[NUM_BITS];
  assign quo       = qs[NUM_BITS];
  assign rem       = rs[NUM_BITS];

endmodule

FILE: tb/fixed_point_alu_q24_8_core_tb.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8_core_tb
// Self-checking bench for the Q24.8 ALU: directed corner items per operation,
// then random items with random gaps on both handshakes, checked in order.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8_core_tb;

  localparam int FRAC = 8;
  localparam int LATENCY = 32 + FRAC + 2;
  localparam logic signed [31:0] MAXV = 32'sh7fffffff;
  localparam logic signed [31:0] MINV = 32'sh80000000;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         order;
    logic [1:0]         status;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] kind = '0;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] value;
  logic [1:0] order;
  logic [1:0] status;

  alu_result_t expected_q[$];
  int errors = 0;
  int mismatches = 0;

  fixed_point_alu_q24_8_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .value(value), .order(order), .status(status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v,
                                                 inout logic [1:0] st);
    if (v > 64'sd2147483647) begin
      st = fxa_pkg::STATUS_OVERFLOW;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      st = fxa_pkg::STATUS_OVERFLOW;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic alu_result_t alu_predict(input logic [3:0] k,
                                              input logic signed [31:0] a32,
                                              input logic signed [31:0] b32);
    alu_result_t r;
    logic signed [63:0] a, b, v;
    logic [63:0] ma, mb, p, q, num, rem;
    logic neg;
    logic [1:0] st;
    a = a32;
    b = b32;
    st = fxa_pkg::STATUS_OK;
    v = 0;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    neg = (a < 0) != (b < 0);
    case (k)
      fxa_pkg::KIND_ADD: v = clamp32(a + b, st);
      fxa_pkg::KIND_SUB: v = clamp32(a - b, st);
      fxa_pkg::KIND_MUL: begin
        p = ma * mb;
        q = (p + (64'd1 << (FRAC - 1))) >> FRAC;
        v = clamp32(neg ? -$signed(q) : $signed(q), st);
      end
      fxa_pkg::KIND_DIV: begin
        if (b == 0) begin
          v = 0;
          st = fxa_pkg::STATUS_DIV_ZERO;
        end else begin
          num = ma << FRAC;
          q = num / mb;
          rem = num % mb;
          if (rem * 2 >= mb) q = q + 1;
          v = clamp32(neg ? -$signed(q) : $signed(q), st);
        end
      end
      fxa_pkg::KIND_MIN: v = a < b ? a : b;
      fxa_pkg::KIND_MAX: v = a > b ? a : b;
      fxa_pkg::KIND_INC: v = clamp32(a + 1, st);
      fxa_pkg::KIND_DEC: v = clamp32(a - 1, st);
      fxa_pkg::KIND_TO_INT: begin
        q = ma >> FRAC;
        v = a < 0 ? -$signed(q) : $signed(q);
      end
      fxa_pkg::KIND_FROM_INT: v = clamp32(a * 64'sd256, st);
      default: v = 0;
    endcase
    r.value = v[31:0];
    r.order = a < b ? fxa_pkg::ORDER_LESS :
              (a == b ? fxa_pkg::ORDER_EQUAL : fxa_pkg::ORDER_GREATER);
    r.status = st;
    return r;
  endfunction

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(input logic [3:0] k, input logic signed [31:0] a,
                           input logic signed [31:0] b);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(alu_predict(k, a, b));
  endtask

  task automatic finish_items();
    in_valid <= 1'b0;
  endtask

  // receiver side stalls
  initial begin
    int g;
    @(negedge rst);
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    alu_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected result value=%h", value);
        mismatches++;
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r.value !== value || exp_r.order !== order ||
            exp_r.status !== status) begin
          errors++;
          if (mismatches < 10)
            $display("mismatch exp v=%h o=%0d s=%0d got v=%h o=%0d s=%0d",
                     exp_r.value, exp_r.order, exp_r.status, value, order, status);
          mismatches++;
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_operand();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return MAXV - $urandom_range(0, 3);
      1: return MINV + $urandom_range(0, 3);
      2: return $signed($urandom_range(0, 1023)) - 512;
      3: return $signed($urandom_range(0, 65535)) - 32768;
      4: return $signed($urandom_range(0, 8388607)) - 4194304;
      5: return 32'(($signed($urandom_range(0, 255)) - 128) <<< FRAC);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_add_sub();
    send_item(fxa_pkg::KIND_ADD, 32'sd256, 32'sd512);
    send_item(fxa_pkg::KIND_ADD, MAXV, 32'sd1);
    send_item(fxa_pkg::KIND_ADD, MINV, -32'sd1);
    send_item(fxa_pkg::KIND_SUB, MINV, 32'sd1);
    send_item(fxa_pkg::KIND_SUB, MAXV, MINV);
  endtask

  task automatic test_mul_div();
    send_item(fxa_pkg::KIND_MUL, 32'sd384, -32'sd384);
    send_item(fxa_pkg::KIND_MUL, 32'sd1, 32'sd128);
    send_item(fxa_pkg::KIND_MUL, -32'sd1, 32'sd128);
    send_item(fxa_pkg::KIND_MUL, MAXV, MAXV);
    send_item(fxa_pkg::KIND_MUL, MINV, MAXV);
    send_item(fxa_pkg::KIND_DIV, 32'sd256, 32'sd0);
    send_item(fxa_pkg::KIND_DIV, 32'sd1, 32'sd512);
    send_item(fxa_pkg::KIND_DIV, -32'sd1, 32'sd512);
    send_item(fxa_pkg::KIND_DIV, MINV, 32'sd1);
    send_item(fxa_pkg::KIND_DIV, MINV, -32'sd1);
    send_item(fxa_pkg::KIND_DIV, MAXV, MINV);
  endtask

  task automatic test_misc_kinds();
    send_item(fxa_pkg::KIND_MIN, MINV, MAXV);
    send_item(fxa_pkg::KIND_MAX, MINV, MAXV);
    send_item(fxa_pkg::KIND_INC, MAXV, 32'sd0);
    send_item(fxa_pkg::KIND_DEC, MINV, 32'sd0);
    send_item(fxa_pkg::KIND_TO_INT, -32'sd257, 32'sd5);
    send_item(fxa_pkg::KIND_TO_INT, MINV, 32'sd0);
    send_item(fxa_pkg::KIND_FROM_INT, 32'sd8388608, 32'sd0);
    send_item(fxa_pkg::KIND_FROM_INT, -32'sd8388609, 32'sd0);
    send_item(fxa_pkg::KIND_COMPARE, 32'sd7, 32'sd7);
    send_item(4'd15, MAXV, MINV);
  endtask

  task automatic test_random(input int n);
    logic signed [31:0] a, b;
    for (int i = 0; i < n; i++) begin
      a = rand_operand();
      b = ($urandom_range(0, 15) == 0) ? a : rand_operand();
      if ($urandom_range(0, 19) == 0) b = 0;
      send_item(4'($urandom_range(0, 15)), a, b);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_add_sub();
    test_mul_div();
    test_misc_kinds();
    test_random(1800);
    finish_items();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS fixed_point_alu_q24_8_core");
    end else begin
      $display("FAIL fixed_point_alu_q24_8_core");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("FAIL fixed_point_alu_q24_8_core");
    $finish;
  end

endmodule
